FILE: src/adaptive_frame_rate_ramp_top_macros.svh
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp assertion macros
// Shorthand for clocked checks that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_FRAME_RATE_RAMP_TOP_MACROS_SVH
`define ADAPTIVE_FRAME_RATE_RAMP_TOP_MACROS_SVH

// Same-cycle implication.
`define AFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afr_checker: same-cycle check failed");

// Next-cycle implication.
`define AFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afr_checker: next-cycle check failed");

`endif

FILE: src/afr_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp package
// Shared widths, register indexes, reset values and request types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  localparam int RUN_W      = 16;
  localparam int RATE_W     = 8;
  localparam int LEN_W      = 16;
  localparam int CMP_W      = (RUN_W > LEN_W) ? RUN_W : LEN_W;
  localparam int NUM_W      = RATE_W + LEN_W;
  localparam int DELAY_W    = 20;
  localparam int DIVD_W     = (NUM_W > DELAY_W) ? NUM_W : DELAY_W;
  localparam int DIVS_W     = (LEN_W > RATE_W) ? LEN_W : RATE_W;
  localparam int MAC_CNT_W  = $clog2(LEN_W);
  localparam int DIV_CNT_W  = $clog2(DIVD_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = ((RATE_W + DELAY_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - RATE_W - DELAY_W;

  localparam logic [DIVD_W-1:0] US_PER_SEC = DIVD_W'(1000000);

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_RATE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_RATE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CEIL   = CFG_IDX_W'(5);

  localparam logic [RATE_W-1:0] IDLE_RATE_RST   = RATE_W'(5);
  localparam logic [RATE_W-1:0] ACTIVE_RATE_RST = RATE_W'(30);
  localparam logic [LEN_W-1:0]  RAMP_LEN_RST    = '0;
  localparam logic [RATE_W-1:0] FLOOR_RST       = RATE_W'(1);
  localparam logic [RATE_W-1:0] CEIL_RST        = RATE_W'(60);

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] from_rate;
    logic [RATE_W-1:0] to_rate;
    logic [LEN_W-1:0]  from_wt;
    logic [LEN_W-1:0]  to_wt;
  } mac_req_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

FILE: src/afr_mac.sv
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp blend multiplier
// Bit-serial sum of two products, weight bits taken most significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afr_mac
  import afr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mac_req_t         req_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      acc_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [MAC_CNT_W-1:0] cnt_q;
  logic [RATE_W-1:0]    a_q;
  logic [RATE_W-1:0]    c_q;
  logic [LEN_W-1:0]     b_q;
  logic [LEN_W-1:0]     d_q;
  logic [NUM_W-1:0]     acc_q;
  logic [NUM_W-1:0]     acc_d;
  logic [NUM_W-1:0]     a_term;
  logic [NUM_W-1:0]     c_term;

  always_comb begin
    a_term = b_q[LEN_W-1] ? NUM_W'(a_q) : '0;
    c_term = d_q[LEN_W-1] ? NUM_W'(c_q) : '0;
    acc_d  = {acc_q[NUM_W-2:0], 1'b0} + a_term + c_term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= MAC_CNT_W'(LEN_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.from_rate;
      c_q   <= req_i.to_rate;
      b_q   <= req_i.from_wt;
      d_q   <= req_i.to_wt;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[LEN_W-2:0], 1'b0};
      d_q   <= {d_q[LEN_W-2:0], 1'b0};
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

FILE: src/afr_div.sv
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp serial divider
// Restoring division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afr_div
  import afr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  output logic                  done_o,
  output logic [DIVD_W-1:0]     quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0]    dvd_q;
  logic [DIVS_W-1:0]    dvs_q;
  logic [DIVS_W-1:0]    rem_q;
  logic [DIVS_W:0]      trial;
  logic [DIVS_W:0]      diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, dvd_q[DIVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      dvd_q <= {dvd_q[DIVD_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

FILE: src/adaptive_frame_rate_ramp_top.sv
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp
// Tracks detection runs and ramps a target frame rate between idle and active.
// ----------------------------------------------------------------------------
// Usage:
// Each frame item enters on the s_axis channel: tuser carries the command
// (0 update, 1 reset runs and rate to idle) and tdata the detection count.
// Each item yields exactly one result item on the m_axis channel with the
// target rate and the frame delay in microseconds.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no item is in flight.
// A ramp item passes through a setup state, the bit-serial blend multiplier,
// two passes through the shared one-bit-per-cycle divider, and control
// states. A zero ramp length and a reset command both skip the multiplier
// and the first division. The block takes no new item until the result of
// the last one is loaded into the output register. When the receiver
// stalls, a second finished result waits inside until the output register
// frees. Reset loads the default registers, clears both runs and sets the
// rate to the default idle rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adaptive_frame_rate_ramp_top
  import afr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // detection count
  input  wire logic                  s_axis_tuser,  // command
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // target_rate, frame_delay_us, zero pad
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_RATE  = 3'd5;
  localparam logic [2:0] ST_DLY   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [RATE_W-1:0]   idle_q, active_q, floor_q, ceil_q;
  logic [LEN_W-1:0]    up_len_q, dn_len_q;
  logic [RUN_W-1:0]    hit_q, hit_d, miss_q, miss_d;
  logic [RATE_W-1:0]   rate_q, rate_d;
  logic [RATE_W-1:0]   v_q, v_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [DELAY_W-1:0]  delay_q, delay_d;
  logic                cmd_q, cmd_d;
  logic                hit_flag_q, hit_flag_d;
  logic                out_valid_q, out_valid_d;
  logic [RATE_W-1:0]   out_rate_q, out_rate_d;
  logic [DELAY_W-1:0]  out_delay_q, out_delay_d;

  logic                in_accept;
  logic [RUN_W-1:0]    run_sel;
  logic [LEN_W-1:0]    len_sel;
  logic [LEN_W-1:0]    k_sel;
  logic [RATE_W-1:0]   from_sel, to_sel;
  mac_req_t            mac_req;
  div_req_t            div_req;
  logic                mac_done, div_done;
  logic [NUM_W-1:0]    mac_acc;
  logic [DIVD_W-1:0]   div_quot;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q   <= IDLE_RATE_RST;
      active_q <= ACTIVE_RATE_RST;
      up_len_q <= RAMP_LEN_RST;
      dn_len_q <= RAMP_LEN_RST;
      floor_q  <= FLOOR_RST;
      ceil_q   <= CEIL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IDLE_RATE:   idle_q   <= cfg_data_i[RATE_W-1:0];
        REG_ACTIVE_RATE: active_q <= cfg_data_i[RATE_W-1:0];
        REG_RAMP_UP:     up_len_q <= cfg_data_i[LEN_W-1:0];
        REG_RAMP_DOWN:   dn_len_q <= cfg_data_i[LEN_W-1:0];
        REG_RATE_FLOOR:  floor_q  <= cfg_data_i[RATE_W-1:0];
        REG_RATE_CEIL:   ceil_q   <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    run_sel  = hit_flag_q ? hit_q : miss_q;
    len_sel  = hit_flag_q ? up_len_q : dn_len_q;
    from_sel = hit_flag_q ? idle_q : active_q;
    to_sel   = hit_flag_q ? active_q : idle_q;
    k_sel    = (CMP_W'(run_sel) < CMP_W'(len_sel)) ? LEN_W'(run_sel) : len_sel;
  end

  always_comb begin
    state_d     = state_q;
    hit_d       = hit_q;
    miss_d      = miss_q;
    rate_d      = rate_q;
    v_d         = v_q;
    len_d       = len_q;
    delay_d     = delay_q;
    cmd_d       = cmd_q;
    hit_flag_d  = hit_flag_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_rate_d  = out_rate_q;
    out_delay_d = out_delay_q;

    mac_req.start     = 1'b0;
    mac_req.from_rate = from_sel;
    mac_req.to_rate   = to_sel;
    mac_req.from_wt   = len_sel - k_sel;
    mac_req.to_wt     = k_sel;

    div_req.start    = 1'b0;
    div_req.dividend = US_PER_SEC;
    div_req.divisor  = DIVS_W'(rate_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_d      = s_axis_tuser;
          hit_flag_d = |s_axis_tdata;
          if (s_axis_tuser) begin
            hit_d  = '0;
            miss_d = '0;
          end else if (|s_axis_tdata) begin
            hit_d  = (hit_q == '1) ? hit_q : hit_q + 1'b1;
            miss_d = '0;
          end else begin
            miss_d = (miss_q == '1) ? miss_q : miss_q + 1'b1;
            hit_d  = '0;
          end
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (cmd_q) begin
          rate_d  = idle_q;
          state_d = ST_RATE;
        end else if (len_sel == '0) begin
          v_d     = to_sel;
          state_d = ST_CLAMP;
        end else begin
          len_d         = len_sel;
          mac_req.start = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mac_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(mac_acc);
          div_req.divisor  = DIVS_W'(len_q);
          state_d          = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          v_d     = div_quot[RATE_W-1:0];
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (v_q < floor_q) begin
          rate_d = floor_q;
        end else if (v_q > ceil_q) begin
          rate_d = ceil_q;
        end else begin
          rate_d = v_q;
        end
        state_d = ST_RATE;
      end
      ST_RATE: begin
        if (rate_q == '0) begin
          delay_d = '0;
          state_d = ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DLY;
        end
      end
      ST_DLY: begin
        if (div_done) begin
          delay_d = div_quot[DELAY_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_rate_d  = rate_q;
          out_delay_d = delay_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hit_q       <= '0;
      miss_q      <= '0;
      rate_q      <= IDLE_RATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      miss_q      <= miss_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    len_q       <= len_d;
    delay_q     <= delay_d;
    cmd_q       <= cmd_d;
    hit_flag_q  <= hit_flag_d;
    out_rate_q  <= out_rate_d;
    out_delay_q <= out_delay_d;
  end

  afr_mac u_afr_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  afr_div u_afr_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_delay_q, out_rate_q};

endmodule

`default_nettype wire

FILE: src/afr_checker.sv
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp checker
// Port-level checks on the stream channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "adaptive_frame_rate_ramp_top_macros.svh"

module afr_checker
  import afr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

  `AFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `AFR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `AFR_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)
  `AFR_ASSERT_IMPL(a_zero_rate_delay, m_axis_tvalid, (m_axis_tdata[RATE_W-1:0] == '0) == (m_axis_tdata[RATE_W+DELAY_W-1:RATE_W] == '0))

endmodule

bind adaptive_frame_rate_ramp_top afr_checker u_afr_checker (.*);

`default_nettype wire

FILE: bench/adaptive_frame_rate_ramp_top_tb.sv
// ----------------------------------------------------------------------------
// Adaptive frame rate ramp testbench
// Drives frame items and register writes into the ramp block. Each accepted
// item goes through a local model of the run counters, the linear ramp and
// the clamp, and the expected rate and frame delay are queued. Each result
// item is then checked against the oldest queued entry. Both handshake sides
// idle at random. The receiver also holds off once for a long stretch, and a
// long detection run is driven before a full-length ramp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_frame_rate_ramp_top_tb;
  import afr_pkg::*;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(7);

  localparam logic [RUN_W-1:0] RUN_ALL_ONES    = '1;
  localparam int               WATCHDOG_LIMIT  = 5000;
  localparam int               LONG_RUN_FRAMES = 40;
  localparam int               PHASE_FRAMES    = 140;

  typedef struct {
    logic [RATE_W-1:0]  rate;
    logic [DELAY_W-1:0] delay;
  } rate_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic [RATE_W-1:0] cfg_idle   = IDLE_RATE_RST;
  logic [RATE_W-1:0] cfg_active = ACTIVE_RATE_RST;
  logic [LEN_W-1:0]  cfg_up     = RAMP_LEN_RST;
  logic [LEN_W-1:0]  cfg_down   = RAMP_LEN_RST;
  logic [RATE_W-1:0] cfg_floor  = FLOOR_RST;
  logic [RATE_W-1:0] cfg_ceil   = CEIL_RST;

  logic [RUN_W-1:0]  hit_run  = '0;
  logic [RUN_W-1:0]  miss_run = '0;
  logic [RATE_W-1:0] rate_now = IDLE_RATE_RST;

  rate_result_t pending_rates[$];
  rate_result_t want;

  bit tx_gaps     = 1'b1;
  bit rx_gaps     = 1'b1;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int mismatches  = 0;
  int frames_sent = 0;
  int cfg_writes  = 0;
  int results_got = 0;

  adaptive_frame_rate_ramp_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [IN_DATA_W-1:0] hit_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 20) return IN_DATA_W'(1);
    return IN_DATA_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [RATE_W-1:0] v);
    return {8'($urandom_range(0, 255)), v};
  endfunction

  function automatic longint unsigned blend_rate(input longint unsigned from_rate,
                                                 input longint unsigned to_rate,
                                                 input longint unsigned run,
                                                 input longint unsigned len);
    longint unsigned k;
    if (len == 0) return to_rate;
    k = (run < len) ? run : len;
    return (from_rate * (len - k) + to_rate * k) / len;
  endfunction

  task automatic predict_frame_rate(input logic cmd, input logic [IN_DATA_W-1:0] det);
    longint unsigned v;
    rate_result_t    res;
    if (cmd == CMD_RESET) begin
      hit_run  = '0;
      miss_run = '0;
      rate_now = cfg_idle;
    end else begin
      if (det != 0) begin
        if (hit_run != RUN_ALL_ONES) hit_run = hit_run + 1'b1;
        miss_run = '0;
        v = blend_rate(cfg_idle, cfg_active, hit_run, cfg_up);
      end else begin
        if (miss_run != RUN_ALL_ONES) miss_run = miss_run + 1'b1;
        hit_run = '0;
        v = blend_rate(cfg_active, cfg_idle, miss_run, cfg_down);
      end
      if (v < cfg_floor) v = cfg_floor;
      else if (v > cfg_ceil) v = cfg_ceil;
      rate_now = v[RATE_W-1:0];
    end
    res.rate  = rate_now;
    res.delay = (rate_now == 0) ? '0 : DELAY_W'(1000000 / int'(rate_now));
    pending_rates.push_back(res);
  endtask

  task automatic send_frame(input logic cmd, input logic [IN_DATA_W-1:0] det);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= det;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame_rate(cmd, det);
    frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_rates.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_IDLE_RATE:   cfg_idle   = data[RATE_W-1:0];
      REG_ACTIVE_RATE: cfg_active = data[RATE_W-1:0];
      REG_RAMP_UP:     cfg_up     = data[LEN_W-1:0];
      REG_RAMP_DOWN:   cfg_down   = data[LEN_W-1:0];
      REG_RATE_FLOOR:  cfg_floor  = data[RATE_W-1:0];
      REG_RATE_CEIL:   cfg_ceil   = data[RATE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_rates(input logic [RATE_W-1:0] idle, input logic [RATE_W-1:0] active,
                           input logic [LEN_W-1:0] up, input logic [LEN_W-1:0] down,
                           input logic [RATE_W-1:0] lo, input logic [RATE_W-1:0] hi);
    wait_drained();
    write_reg(REG_IDLE_RATE, with_junk(idle));
    write_reg(REG_ACTIVE_RATE, with_junk(active));
    write_reg(REG_RAMP_UP, up);
    write_reg(REG_RAMP_DOWN, down);
    write_reg(REG_RATE_FLOOR, with_junk(lo));
    write_reg(REG_RATE_CEIL, with_junk(hi));
  endtask

  task automatic test_reset_defaults();
    send_frame(CMD_UPDATE, '0);
    send_frame(CMD_UPDATE, '1);
    send_frame(CMD_UPDATE, IN_DATA_W'(1));
    send_frame(CMD_RESET, '1);
    send_frame(CMD_RESET, '0);
    send_frame(CMD_UPDATE, IN_DATA_W'(16'h8000));
  endtask

  task automatic test_ignored_index();
    wait_drained();
    write_reg(REG_UNUSED_A, '1);
    write_reg(REG_UNUSED_B, '0);
    send_frame(CMD_UPDATE, IN_DATA_W'(16'h00F0));
    send_frame(CMD_UPDATE, '0);
  endtask

  task automatic test_register_extremes();
    set_rates('0, '0, '0, '0, '0, '0);
    send_frame(CMD_UPDATE, '1);
    send_frame(CMD_UPDATE, '0);
    send_frame(CMD_RESET, IN_DATA_W'(16'h5A5A));
    set_rates('1, '1, '1, '1, '1, '1);
    send_frame(CMD_UPDATE, '1);
    send_frame(CMD_UPDATE, '0);
    // Floor above ceiling: values below the floor take the floor, all others the ceiling.
    set_rates(8'd10, 8'd250, 16'd4, 16'd3, 8'd200, 8'd20);
    repeat (4) send_frame(CMD_UPDATE, hit_count());
    send_frame(CMD_UPDATE, '0);
    // Active below idle, so the ramp runs downward on detections.
    set_rates(8'd200, 8'd3, 16'd5, 16'd2, 8'd0, 8'd255);
    repeat (3) send_frame(CMD_UPDATE, hit_count());
    repeat (3) send_frame(CMD_UPDATE, '0);
    send_frame(CMD_RESET, '0);
  endtask

  // A long detection run is driven with an immediate ramp, then a
  // full-length ramp shows whether the run count carried over.
  task automatic test_long_run();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_rates(8'd5, 8'd200, '0, '0, '0, '1);
    repeat (LONG_RUN_FRAMES) send_frame(CMD_UPDATE, hit_count());
    set_rates(8'd5, 8'd200, '1, '0, '0, '1);
    send_frame(CMD_UPDATE, hit_count());
    send_frame(CMD_UPDATE, '0);
  endtask

  task automatic random_config();
    logic [RATE_W-1:0] idle, active, lo, hi;
    logic [LEN_W-1:0]  len [2];
    int                r;
    idle   = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                          : RATE_W'($urandom_range(0, 255));
    active = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                          : RATE_W'($urandom_range(0, 255));
    for (int i = 0; i < 2; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) len[i] = '0;
      else if (r < 70) len[i] = LEN_W'($urandom_range(1, 24));
      else if (r < 90) len[i] = LEN_W'($urandom_range(25, 300));
      else len[i] = $urandom_range(0, 1) ? '1 : LEN_W'($urandom_range(301, 65535));
    end
    r = $urandom_range(0, 3);
    if (r < 2) begin
      lo = RATE_W'($urandom_range(0, 30));
      hi = RATE_W'($urandom_range(200, 255));
    end else if (r == 2) begin
      lo = RATE_W'($urandom_range(0, 255));
      hi = RATE_W'($urandom_range(0, 255));
    end else begin
      lo = '0;
      hi = '1;
    end
    set_rates(idle, active, len[0], len[1], lo, hi);
  endtask

  task automatic test_random_ramps();
    int sent, r, n, span;
    for (int phase = 0; phase < 8; phase++) begin
      random_config();
      tx_gaps = (phase % 3) != 2;
      rx_gaps = (phase % 4) != 3;
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_frame(CMD_RESET, IN_DATA_W'($urandom_range(0, 65535)));
          sent++;
        end else if (r < 14) begin
          send_frame(CMD_UPDATE, (r < 10) ? '0 : IN_DATA_W'($urandom_range(0, 65535)));
          sent++;
        end else begin
          span = ((cfg_up < 30) ? int'(cfg_up) : 30) + 3;
          n = $urandom_range(1, span);
          repeat (n) send_frame(CMD_UPDATE, hit_count());
          sent += n;
          span = ((cfg_down < 30) ? int'(cfg_down) : 30) + 3;
          n = $urandom_range(1, span);
          repeat (n) send_frame(CMD_UPDATE, '0);
          sent += n;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    wait_drained();
    hold_cycles = 800;
    repeat (16) begin
      send_frame(CMD_UPDATE, $urandom_range(0, 2) ? hit_count() : '0);
    end
  endtask

  task automatic test_drain_pause();
    tx_gaps = 1'b1;
    repeat (3) begin
      repeat (5) send_frame($urandom_range(0, 9) == 0, IN_DATA_W'($urandom_range(0, 65535)));
      wait_drained();
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (!rx_gaps) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_got++;
      if (pending_rates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no frame pending: rate %0d delay %0d",
                   m_axis_tdata[RATE_W-1:0], m_axis_tdata[RATE_W+DELAY_W-1:RATE_W]);
        end
      end else begin
        want = pending_rates.pop_front();
        if (m_axis_tdata[RATE_W-1:0] !== want.rate ||
            m_axis_tdata[RATE_W+DELAY_W-1:RATE_W] !== want.delay ||
            m_axis_tdata[OUT_DATA_W-1:RATE_W+DELAY_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected rate %0d delay %0d, got rate %0d delay %0d pad %0h",
                     $realtime, want.rate, want.delay, m_axis_tdata[RATE_W-1:0],
                     m_axis_tdata[RATE_W+DELAY_W-1:RATE_W],
                     m_axis_tdata[OUT_DATA_W-1:RATE_W+DELAY_W]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_rates.size());
      $display("adaptive_frame_rate_ramp_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_reset_defaults();
    test_ignored_index();
    test_register_extremes();
    test_long_run();
    test_random_ramps();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (pending_rates.size() != 0) mismatches++;
    $display("Covered %0d frames, %0d register writes and %0d results with %0d mismatches.",
             frames_sent, cfg_writes, results_got, mismatches);
    $display("Cases: ramps both ways, zero and full lengths, inverted clamps, zero rate, %s",
             "reset commands, ignored indexes, a long detection run and a long output stall.");
    if (mismatches == 0) begin
      $display("adaptive_frame_rate_ramp_top test passed");
    end else begin
      $display("adaptive_frame_rate_ramp_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/afr_pkg.sv
src/afr_mac.sv
src/afr_div.sv
src/adaptive_frame_rate_ramp_top.sv
src/afr_checker.sv
bench/adaptive_frame_rate_ramp_top_tb.sv
